// ----- sv/mmq_pkg.sv -----
// Package for the message mailbox: request and result beat types, request
// and status codes, and the default sizes of the mailbox.
// No dependencies; every other file of the block imports it.
package mmq_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int NumMessagesDef = 4;
    localparam int QueueDepthDef  = 8;
    localparam int DataWidthDef   = 32;

    // Width of one length field in the queue length register.
    localparam int LenW  = 4;
    localparam int QlenW = 16;

    // Request codes.
    localparam logic [2:0] REQ_SEND = 3'd0;
    localparam logic [2:0] REQ_RECV = 3'd1;
    localparam logic [2:0] REQ_STAT = 3'd2;
    localparam logic [2:0] REQ_GET  = 3'd3;
    localparam logic [2:0] REQ_REL  = 3'd4;

    // Status codes.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_ID    = 3'd1;
    localparam logic [2:0] ST_BUSY  = 3'd2;
    localparam logic [2:0] ST_NOMSG = 3'd3;
    localparam logic [2:0] ST_LIMIT = 3'd4;

    // One request beat.
    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  msg_id;
        logic [31:0] data_in;
    } t_request;

    // One result beat.
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] data_out;
    } t_result;

    // Outcome of the control stage for one request.
    typedef struct packed {
        logic [2:0] status;
        logic       use_data;
    } t_ctrl_res;

endpackage

// ----- sv/mmq_store.sv -----
// Message word store of the mailbox: one write and one registered read per
// cycle, with a valid bit per word so that unwritten words read as zero.
// Depends on mmq_pkg.
module mmq_store
    import mmq_pkg::*;
#(
    parameter int Depth     = NumMessagesDef * QueueDepthDef,
    parameter int DataWidth = DataWidthDef,
    parameter int AddrW     = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [AddrW-1:0]     i_waddr,
    input  logic [DataWidth-1:0] i_wdata,
    input  logic [AddrW-1:0]     i_raddr,
    output logic [DataWidth-1:0] o_rdata,
    output logic                 o_rvalid
);

    logic [DataWidth-1:0] r_mem [Depth];
    logic [Depth-1:0]     r_vbit;
    logic [DataWidth-1:0] r_rdata;
    logic                 r_rvalid;

    // Word array: write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata  <= r_mem[i_raddr];
        r_rvalid <= r_vbit[i_raddr];
    end

    // Valid bits stand in for the all-zero reset of the words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbit <= '0;
        end else if (i_we) begin
            r_vbit[i_waddr] <= 1'b1;
        end
    end

    assign o_rdata  = r_rdata;
    assign o_rvalid = r_rvalid;

endmodule

// ----- sv/mmq_ctrl.sv -----
// Control stage of the mailbox: per-object queue pointers, fill counts and
// flags, request decode, status and store addressing for one request beat.
// Depends on mmq_pkg.
module mmq_ctrl
    import mmq_pkg::*;
#(
    parameter int NumMessages = NumMessagesDef,
    parameter int QueueDepth  = QueueDepthDef,
    parameter int DataWidth   = DataWidthDef,
    parameter int AddrW       = (NumMessages * QueueDepth > 1) ?
                                $clog2(NumMessages * QueueDepth) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_request             i_req,
    input  logic [QlenW-1:0]     i_qlen,
    output logic                 o_we,
    output logic [AddrW-1:0]     o_waddr,
    output logic [DataWidth-1:0] o_wdata,
    output logic [AddrW-1:0]     o_raddr,
    output t_ctrl_res            o_res
);

    localparam int IdW   = (NumMessages > 1) ? $clog2(NumMessages) : 1;
    localparam int PosW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int FillW = $clog2(QueueDepth + 1);

    logic [PosW-1:0]        r_wpos [NumMessages];
    logic [PosW-1:0]        r_rpos [NumMessages];
    logic [FillW-1:0]       r_fill [NumMessages];
    logic [NumMessages-1:0] r_ovf;
    logic [NumMessages-1:0] r_bsy;

    logic [PosW-1:0]        n_wpos [NumMessages];
    logic [PosW-1:0]        n_rpos [NumMessages];
    logic [FillW-1:0]       n_fill [NumMessages];
    logic [NumMessages-1:0] n_ovf;
    logic [NumMessages-1:0] n_bsy;

    logic             id_ok;
    logic [IdW-1:0]   idx;
    logic [LenW-1:0]  raw_len;
    logic [LenW-1:0]  len;
    logic [LenW-1:0]  fill_ext;
    logic [AddrW-1:0] base;
    logic             fifo;

    // Next position in a ring of the given length.
    function automatic logic [PosW-1:0] advance(input logic [PosW-1:0] pos,
                                                input logic [LenW-1:0] qlen);
        logic [LenW:0] nxt;
        nxt = (LenW + 1)'(pos) + 1'b1;
        if (nxt >= {1'b0, qlen}) begin
            return '0;
        end
        return PosW'(nxt);
    endfunction

    // Object selection and its clamped queue length.
    always_comb begin
        id_ok   = {1'b0, i_req.msg_id} < 4'(NumMessages);
        idx     = IdW'(i_req.msg_id);
        raw_len = i_req.msg_id[2] ? '0 : i_qlen[{i_req.msg_id[1:0], 2'b00} +: LenW];
        len     = (raw_len > LenW'(QueueDepth)) ? LenW'(QueueDepth) : raw_len;
        fifo    = (len != '0);
        base    = AddrW'(idx) * AddrW'(QueueDepth);
    end

    assign fill_ext = LenW'(r_fill[idx]);
    assign o_wdata  = DataWidth'(i_req.data_in);

    // Request decode and next state of the selected object.
    always_comb begin
        n_wpos       = r_wpos;
        n_rpos       = r_rpos;
        n_fill       = r_fill;
        n_ovf        = r_ovf;
        n_bsy        = r_bsy;
        o_we         = 1'b0;
        o_waddr      = base;
        o_raddr      = base;
        o_res.status   = ST_OK;
        o_res.use_data = 1'b0;
        if (i_valid) begin
            if (!id_ok) begin
                o_res.status = ST_ID;
            end else begin
                case (i_req.req_type)
                    REQ_SEND: begin
                        if (!fifo) begin
                            o_we = 1'b1;
                        end else if (fill_ext >= len) begin
                            n_ovf[idx] = 1'b1;
                        end else begin
                            o_we         = 1'b1;
                            o_waddr      = base + AddrW'(r_wpos[idx]);
                            n_wpos[idx]  = advance(r_wpos[idx], len);
                            n_fill[idx]  = r_fill[idx] + 1'b1;
                        end
                    end
                    REQ_RECV: begin
                        if (!fifo) begin
                            o_res.use_data = 1'b1;
                        end else if (r_fill[idx] == '0) begin
                            o_res.status = ST_NOMSG;
                        end else begin
                            if (r_ovf[idx]) begin
                                o_res.status = ST_LIMIT;
                                n_ovf[idx]   = 1'b0;
                            end
                            o_res.use_data = 1'b1;
                            o_raddr        = base + AddrW'(r_rpos[idx]);
                            n_rpos[idx]    = advance(r_rpos[idx], len);
                            n_fill[idx]    = r_fill[idx] - 1'b1;
                        end
                    end
                    REQ_STAT: begin
                        if (r_bsy[idx]) begin
                            o_res.status = ST_BUSY;
                        end else if (fifo && r_fill[idx] == '0) begin
                            o_res.status = ST_NOMSG;
                        end else if (fifo && r_ovf[idx]) begin
                            o_res.status = ST_LIMIT;
                        end
                    end
                    REQ_GET: begin
                        if (r_bsy[idx]) begin
                            o_res.status = ST_BUSY;
                        end else begin
                            n_bsy[idx] = 1'b1;
                        end
                    end
                    REQ_REL: begin
                        n_bsy[idx] = 1'b0;
                    end
                    default: begin
                        o_res.status = ST_OK;
                    end
                endcase
            end
        end
    end

    // Per-object state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumMessages; i++) begin
                r_wpos[i] <= '0;
                r_rpos[i] <= '0;
                r_fill[i] <= '0;
            end
            r_ovf <= '0;
            r_bsy <= '0;
        end else begin
            r_wpos <= n_wpos;
            r_rpos <= n_rpos;
            r_fill <= n_fill;
            r_ovf  <= n_ovf;
            r_bsy  <= n_bsy;
        end
    end

endmodule

// ----- sv/message_mailbox_with_queues.sv -----
// Top level of the message mailbox: request register, control stage,
// word store and result register. Depends on mmq_pkg, mmq_ctrl, mmq_store.
//
// Use of the block:
// - Requests enter on i_request and are taken at a clock edge where start
//   is high and busy is low. busy is low at all times outside reset, so a
//   request can be issued in every cycle.
// - Each request gives exactly one result beat on o_result, shown for one
//   cycle with o_strobe high. The receiver has no way to stall and must
//   take the beat in that cycle.
// - A request taken at a clock edge is held in the request register, and its
//   result is strobed from the result stage that the request register feeds.
// - Throughput is one request per cycle. The request register feeds the
//   control stage, which updates the object's pointers and flags and
//   addresses the word store; the store's registered read port and the
//   status register form the result stage.
// - The queue length register is written on the i_cfg channel, which is
//   always ready. It may change only while no request is in flight.
// - Reset clears all pointers, fill counts, flags and word valid bits, so
//   every word reads as zero until it is sent.
module message_mailbox_with_queues
    import mmq_pkg::*;
#(
    parameter int NUM_MESSAGES = NumMessagesDef,
    parameter int QUEUE_DEPTH  = QueueDepthDef,
    parameter int DATA_WIDTH   = DataWidthDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_request         i_request,
    output logic             o_strobe,
    output t_result          o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [QlenW-1:0] i_cfg_data
);

    localparam int Depth = NUM_MESSAGES * QUEUE_DEPTH;
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

    logic                  r_in_valid;
    t_request              r_in_req;
    logic [QlenW-1:0]      r_qlen;
    logic                  r_out_valid;
    t_ctrl_res             r_out_ctl;

    logic                  mem_we;
    logic [AddrW-1:0]      mem_waddr;
    logic [AddrW-1:0]      mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [DATA_WIDTH-1:0] mem_rdata;
    logic                  mem_rvalid;
    t_ctrl_res             ctl_res;

    assign busy        = ~i_rst_n;
    assign o_cfg_ready = 1'b1;

    // Queue length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_qlen <= i_cfg_data;
        end
    end

    // Request register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        r_in_req <= i_request;
    end

    mmq_ctrl #(
        .NumMessages (NUM_MESSAGES),
        .QueueDepth  (QUEUE_DEPTH),
        .DataWidth   (DATA_WIDTH),
        .AddrW       (AddrW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_req   (r_in_req),
        .i_qlen  (r_qlen),
        .o_we    (mem_we),
        .o_waddr (mem_waddr),
        .o_wdata (mem_wdata),
        .o_raddr (mem_raddr),
        .o_res   (ctl_res)
    );

    mmq_store #(
        .Depth     (Depth),
        .DataWidth (DATA_WIDTH),
        .AddrW     (AddrW)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdata  (mem_wdata),
        .i_raddr  (mem_raddr),
        .o_rdata  (mem_rdata),
        .o_rvalid (mem_rvalid)
    );

    // Result register; the word itself sits in the store's read register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
        r_out_ctl <= ctl_res;
    end

    // Result beat.
    assign o_strobe          = r_out_valid;
    assign o_result.status   = r_out_ctl.status;
    assign o_result.data_out = (r_out_ctl.use_data && mem_rvalid) ? 32'(mem_rdata) : '0;

`ifndef SYNTHESIS
    // Every result beat comes from an earlier request taken with start high and busy low.
    a_result_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 2))
        else $error("result beat without a matching request");

    // Only a successful or overflow-reporting receive carries a word.
    a_data_only_on_receive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != ST_OK && o_result.status != ST_LIMIT)
            |-> o_result.data_out == '0)
        else $error("data returned with a failing status");

    // Limit is reported only for a receive or a status query.
    a_limit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_LIMIT)
            |-> ($past(i_request.req_type, 2) == REQ_RECV
                 || $past(i_request.req_type, 2) == REQ_STAT))
        else $error("limit status for a request that cannot report it");
`endif

endmodule
